>>> sv/btu_pkg.sv
// Shared types and constants for the branch target unit.
package btu_pkg;

    // Branch kinds carried on the request channel
    typedef enum logic [3:0] {
        OP_BX          = 4'd0,
        OP_BLX_REG     = 4'd1,
        OP_B           = 4'd2,
        OP_BL          = 4'd3,
        OP_BLX_IMM     = 4'd4,
        OP_BX_THUMB    = 4'd5,
        OP_BLX_REG_T   = 4'd6,
        OP_BCOND_THUMB = 4'd7,
        OP_B_THUMB     = 4'd8,
        OP_BL_PREFIX   = 4'd9,
        OP_BL_SUFFIX   = 4'd10,
        OP_BLX_SUFFIX  = 4'd11
    } op_t;

    // Condition codes of the Thumb conditional branch
    typedef enum logic [3:0] {
        COND_EQ = 4'd0,
        COND_NE = 4'd1,
        COND_CS = 4'd2,
        COND_CC = 4'd3,
        COND_MI = 4'd4,
        COND_PL = 4'd5,
        COND_VS = 4'd6,
        COND_VC = 4'd7,
        COND_HI = 4'd8,
        COND_LS = 4'd9,
        COND_GE = 4'd10,
        COND_LT = 4'd11,
        COND_GT = 4'd12,
        COND_LE = 4'd13,
        COND_AL = 4'd14,
        COND_NV = 4'd15
    } cond_t;

    // Link offsets for ARM and Thumb forms
    localparam logic [31:0] LINK_ARM   = 32'hFFFF_FFFC;
    localparam logic [31:0] LINK_THUMB = 32'hFFFF_FFFF;

    // Cycle costs
    localparam logic [1:0] CYCLES_TAKEN = 2'd3;
    localparam logic [1:0] CYCLES_NONE  = 2'd1;

    // Decoded item: adder operands plus write enables
    typedef struct packed {
        logic [31:0] npc_a;
        logic [31:0] npc_b;
        logic [31:0] nlr_a;
        logic [31:0] nlr_b;
        logic        pc_write;
        logic        lr_write;
        logic        thumb;
    } dec_t;

endpackage

>>> sv/btu_req_if.sv
// Request channel: one branch item with valid/ready handshake.
interface btu_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  op;
    logic [31:0] instruction;
    logic [31:0] pc_value;
    logic [31:0] lr_value;
    logic [31:0] reg_value;
    logic [3:0]  flags;
    logic        thumb_in;

    modport source (
        output valid, op, instruction, pc_value, lr_value, reg_value, flags, thumb_in,
        input  ready
    );
    modport sink (
        input  valid, op, instruction, pc_value, lr_value, reg_value, flags, thumb_in,
        output ready
    );
endinterface

>>> sv/btu_rsp_if.sv
// Response channel: one branch result with valid/ready handshake.
interface btu_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] pc_out;
    logic        pc_write;
    logic [31:0] lr_out;
    logic        lr_write;
    logic        thumb_out;
    logic        flush;
    logic [1:0]  cycles;

    modport source (
        output valid, pc_out, pc_write, lr_out, lr_write, thumb_out, flush, cycles,
        input  ready
    );
    modport sink (
        input  valid, pc_out, pc_write, lr_out, lr_write, thumb_out, flush, cycles,
        output ready
    );
endinterface

>>> sv/btu_decode.sv
// Input stage and branch decode: offsets, condition check, adder operands.
module btu_decode (
    input  logic              clk,
    input  logic              rst_n,
    btu_req_if.sink           req,
    input  logic              blx_disabled,
    output btu_pkg::dec_t     dec,
    output logic              dec_valid,
    input  logic              dec_ready
);

    logic        s1_valid_reg;
    logic [3:0]  op_reg;
    logic [31:0] ins_reg;
    logic [31:0] pc_reg;
    logic [31:0] lr_reg;
    logic [31:0] rv_reg;
    logic [3:0]  flags_reg;
    logic        thumb_reg;

    logic [31:0] arm_off;
    logic [31:0] t11_off;
    logic [31:0] t8_off;
    logic [31:0] sfx_off;
    logic        cond_ok;
    logic        blx_kind;
    logic        n_f, z_f, c_f, v_f;

    // Accept when the stage is empty or drains this cycle
    assign req.ready = !s1_valid_reg || dec_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    // Capture the item payload
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg    <= req.op;
            ins_reg   <= req.instruction;
            pc_reg    <= req.pc_value;
            lr_reg    <= req.lr_value;
            rv_reg    <= req.reg_value;
            flags_reg <= req.flags;
            thumb_reg <= req.thumb_in;
        end
    end

    // Sign-extend the immediate offsets; the BL suffix offset is zero-extended
    assign arm_off = {{6{ins_reg[23]}}, ins_reg[23:0], 2'b00};
    assign t11_off = {{20{ins_reg[10]}}, ins_reg[10:0], 1'b0};
    assign t8_off  = {{23{ins_reg[7]}}, ins_reg[7:0], 1'b0};
    assign sfx_off = {20'd0, ins_reg[10:0], 1'b0};

    assign {n_f, z_f, c_f, v_f} = flags_reg;

    // Evaluate the Thumb condition field
    always_comb
    begin
        unique case (btu_pkg::cond_t'(ins_reg[11:8]))
            btu_pkg::COND_EQ: cond_ok = z_f;
            btu_pkg::COND_NE: cond_ok = !z_f;
            btu_pkg::COND_CS: cond_ok = c_f;
            btu_pkg::COND_CC: cond_ok = !c_f;
            btu_pkg::COND_MI: cond_ok = n_f;
            btu_pkg::COND_PL: cond_ok = !n_f;
            btu_pkg::COND_VS: cond_ok = v_f;
            btu_pkg::COND_VC: cond_ok = !v_f;
            btu_pkg::COND_HI: cond_ok = c_f && !z_f;
            btu_pkg::COND_LS: cond_ok = !c_f || z_f;
            btu_pkg::COND_GE: cond_ok = (n_f == v_f);
            btu_pkg::COND_LT: cond_ok = (n_f != v_f);
            btu_pkg::COND_GT: cond_ok = !z_f && (n_f == v_f);
            btu_pkg::COND_LE: cond_ok = z_f || (n_f != v_f);
            default:          cond_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        case (btu_pkg::op_t'(op_reg))
            btu_pkg::OP_BLX_REG, btu_pkg::OP_BLX_IMM,
            btu_pkg::OP_BLX_REG_T, btu_pkg::OP_BLX_SUFFIX: blx_kind = 1'b1;
            default:                                        blx_kind = 1'b0;
        endcase
    end

    // Select adder operands per branch kind; untouched registers pass through
    always_comb
    begin
        dec.npc_a    = pc_reg;
        dec.npc_b    = 32'd0;
        dec.nlr_a    = lr_reg;
        dec.nlr_b    = 32'd0;
        dec.pc_write = 1'b0;
        dec.lr_write = 1'b0;
        dec.thumb    = thumb_reg;
        if (!(blx_kind && blx_disabled))
        begin
            unique case (btu_pkg::op_t'(op_reg))
                btu_pkg::OP_BX, btu_pkg::OP_BX_THUMB:
                begin
                    dec.npc_a    = rv_reg;
                    dec.thumb    = rv_reg[0];
                    dec.pc_write = 1'b1;
                end
                btu_pkg::OP_BLX_REG:
                begin
                    dec.npc_a    = rv_reg;
                    dec.thumb    = rv_reg[0];
                    dec.pc_write = 1'b1;
                    dec.nlr_a    = pc_reg;
                    dec.nlr_b    = btu_pkg::LINK_ARM;
                    dec.lr_write = 1'b1;
                end
                btu_pkg::OP_B:
                begin
                    dec.npc_b    = arm_off;
                    dec.pc_write = 1'b1;
                end
                btu_pkg::OP_BL:
                begin
                    dec.npc_b    = arm_off;
                    dec.pc_write = 1'b1;
                    dec.nlr_a    = pc_reg;
                    dec.nlr_b    = btu_pkg::LINK_ARM;
                    dec.lr_write = 1'b1;
                end
                btu_pkg::OP_BLX_IMM:
                begin
                    dec.npc_b    = arm_off | {30'd0, ins_reg[24], 1'b0};
                    dec.thumb    = 1'b1;
                    dec.pc_write = 1'b1;
                    dec.nlr_a    = pc_reg;
                    dec.nlr_b    = btu_pkg::LINK_ARM;
                    dec.lr_write = 1'b1;
                end
                btu_pkg::OP_BLX_REG_T:
                begin
                    dec.npc_a    = rv_reg;
                    dec.thumb    = rv_reg[0];
                    dec.pc_write = 1'b1;
                    dec.nlr_a    = pc_reg;
                    dec.nlr_b    = btu_pkg::LINK_THUMB;
                    dec.lr_write = 1'b1;
                end
                btu_pkg::OP_BCOND_THUMB:
                begin
                    if (cond_ok)
                    begin
                        dec.npc_b    = t8_off;
                        dec.pc_write = 1'b1;
                    end
                end
                btu_pkg::OP_B_THUMB:
                begin
                    dec.npc_b    = t11_off;
                    dec.pc_write = 1'b1;
                end
                btu_pkg::OP_BL_PREFIX:
                begin
                    dec.nlr_a    = pc_reg;
                    dec.nlr_b    = {t11_off[20:0], 11'd0};
                    dec.lr_write = 1'b1;
                end
                btu_pkg::OP_BL_SUFFIX, btu_pkg::OP_BLX_SUFFIX:
                begin
                    dec.npc_a    = lr_reg;
                    dec.npc_b    = sfx_off;
                    dec.pc_write = 1'b1;
                    dec.nlr_a    = pc_reg;
                    dec.nlr_b    = btu_pkg::LINK_THUMB;
                    dec.lr_write = 1'b1;
                    if (btu_pkg::op_t'(op_reg) == btu_pkg::OP_BLX_SUFFIX)
                    begin
                        dec.thumb = 1'b0;
                    end
                end
                default:
                begin
                    dec.pc_write = 1'b0;
                end
            endcase
        end
    end

    assign dec_valid = s1_valid_reg;

endmodule

>>> sv/btu_exec.sv
// Operand stage, target and link adders, and the result register.
module btu_exec (
    input  logic              clk,
    input  logic              rst_n,
    input  btu_pkg::dec_t     dec,
    input  logic              dec_valid,
    output logic              dec_ready,
    btu_rsp_if.source         rsp
);

    logic          s2_valid_reg;
    btu_pkg::dec_t s2_reg;
    logic          s3_ready;
    logic          rsp_valid_reg;
    logic [31:0]   pc_out_reg;
    logic          pc_write_reg;
    logic [31:0]   lr_out_reg;
    logic          lr_write_reg;
    logic          thumb_out_reg;
    logic [31:0]   npc_sum;
    logic [31:0]   nlr_sum;

    // Advance each stage when its successor has room
    assign s3_ready  = !rsp_valid_reg || rsp.ready;
    assign dec_ready = !s2_valid_reg || s3_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (dec_ready)
            begin
                s2_valid_reg <= dec_valid;
            end
            if (s3_ready)
            begin
                rsp_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Hold decoded operands
    always_ff @(posedge clk)
    begin
        if (dec_valid && dec_ready)
        begin
            s2_reg <= dec;
        end
    end

    // Form the new PC and LR
    assign npc_sum = s2_reg.npc_a + s2_reg.npc_b;
    assign nlr_sum = s2_reg.nlr_a + s2_reg.nlr_b;

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s3_ready)
        begin
            pc_out_reg    <= npc_sum;
            pc_write_reg  <= s2_reg.pc_write;
            lr_out_reg    <= nlr_sum;
            lr_write_reg  <= s2_reg.lr_write;
            thumb_out_reg <= s2_reg.thumb;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.pc_out    = pc_out_reg;
    assign rsp.pc_write  = pc_write_reg;
    assign rsp.lr_out    = lr_out_reg;
    assign rsp.lr_write  = lr_write_reg;
    assign rsp.thumb_out = thumb_out_reg;
    assign rsp.flush     = pc_write_reg;
    assign rsp.cycles    = pc_write_reg ? btu_pkg::CYCLES_TAKEN : btu_pkg::CYCLES_NONE;

    // A PC that is not written must come through unchanged
    a_pc_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_reg.pc_write) |-> (s2_reg.npc_b == 32'd0))
        else $error("unwritten PC has a nonzero offset");

    // An LR that is not written must come through unchanged
    a_lr_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_reg.lr_write) |-> (s2_reg.nlr_b == 32'd0))
        else $error("unwritten LR has a nonzero offset");

    // A stalled operand stage keeps its item
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s3_ready) |=> (s2_valid_reg && $stable(s2_reg)))
        else $error("operand stage lost an item under stall");

    // A waiting result is never overwritten by the next one
    a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |=> (rsp_valid_reg && $stable(pc_out_reg)))
        else $error("result register changed under stall");

endmodule

>>> sv/branch_target_unit.sv
// Top level of the branch target unit.
//
// Resolves one ARM or Thumb branch per item. Items enter on the req channel
// (valid/ready) with the branch kind, instruction word, PC, LR, the named
// register value, NZCV flags and the Thumb bit. Results leave on the rsp
// channel with the new PC and LR, their write enables, the Thumb bit, a
// flush mark and the reported cycle cost.
// The cfg port sets blx_disabled; write it only while no item is in flight.
// Throughput: one item per cycle while rsp.ready stays high; the pipeline
// has three register stages (input capture, decoded operands, result)
// and the two 32-bit adders in the middle stage set the cycle time.
// Reset clears all stage valid bits and sets blx_disabled to 0.
// When rsp.ready is low, each full stage holds its item; req.ready drops
// only once all three stages are full, so nothing is lost or repeated.
module branch_target_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    btu_req_if.sink    req,
    btu_rsp_if.source  rsp
);

    logic          blx_disabled_reg;
    btu_pkg::dec_t dec;
    logic          dec_valid;
    logic          dec_ready;

    // Hold the core-variant register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blx_disabled_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            blx_disabled_reg <= cfg_wdata;
        end
    end

    btu_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .blx_disabled (blx_disabled_reg),
        .dec          (dec),
        .dec_valid    (dec_valid),
        .dec_ready    (dec_ready)
    );

    btu_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec       (dec),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready),
        .rsp       (rsp)
    );

endmodule

>>> verif/btu_branch_checker.sv
// Checker for the branch target unit: predicts each result and compares it.
`timescale 1ns / 1ps

module btu_branch_checker (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    btu_req_if   req,
    btu_rsp_if   rsp,
    output int   mismatch_count,
    output int   in_flight
);

    typedef struct packed {
        logic [31:0] pc;
        logic        pc_we;
        logic [31:0] lr;
        logic        lr_we;
        logic        thumb;
        logic        flush;
        logic [1:0]  cycles;
    } branch_result_t;

    branch_result_t expected_results[$];
    branch_result_t want;
    branch_result_t got;
    logic           blx_off;
    int             bad_results;

    // Evaluate a Thumb condition code against N Z C V
    function automatic logic cond_holds(input btu_pkg::cond_t code, input logic [3:0] fl);
        logic n;
        logic z;
        logic c;
        logic v;
        n = fl[3];
        z = fl[2];
        c = fl[1];
        v = fl[0];
        case (code)
            btu_pkg::COND_EQ: return z;
            btu_pkg::COND_NE: return !z;
            btu_pkg::COND_CS: return c;
            btu_pkg::COND_CC: return !c;
            btu_pkg::COND_MI: return n;
            btu_pkg::COND_PL: return !n;
            btu_pkg::COND_VS: return v;
            btu_pkg::COND_VC: return !v;
            btu_pkg::COND_HI: return c && !z;
            btu_pkg::COND_LS: return !c || z;
            btu_pkg::COND_GE: return n == v;
            btu_pkg::COND_LT: return n != v;
            btu_pkg::COND_GT: return !z && (n == v);
            btu_pkg::COND_LE: return z || (n != v);
            default:          return 1'b0;
        endcase
    endfunction

    // Work out the new PC, LR and Thumb bit for one branch item
    function automatic branch_result_t resolve_branch(
        input logic [3:0]  op_code,
        input logic [31:0] ins,
        input logic [31:0] pc,
        input logic [31:0] lr,
        input logic [31:0] rv,
        input logic [3:0]  fl,
        input logic        th,
        input logic        blx_refused
    );
        branch_result_t r;
        btu_pkg::op_t   kind;
        logic           blx_kind;
        logic [31:0]    arm_off;
        logic [31:0]    t11_off;
        logic [31:0]    t8_off;
        logic [31:0]    suffix_off;
        kind       = btu_pkg::op_t'(op_code);
        arm_off    = {{6{ins[23]}}, ins[23:0], 2'b00};
        t11_off    = {{20{ins[10]}}, ins[10:0], 1'b0};
        t8_off     = {{23{ins[7]}}, ins[7:0], 1'b0};
        suffix_off = {20'd0, ins[10:0], 1'b0};
        blx_kind   = (kind == btu_pkg::OP_BLX_REG) || (kind == btu_pkg::OP_BLX_IMM) ||
                     (kind == btu_pkg::OP_BLX_REG_T) || (kind == btu_pkg::OP_BLX_SUFFIX);
        r.pc    = pc;
        r.lr    = lr;
        r.thumb = th;
        r.pc_we = 1'b0;
        r.lr_we = 1'b0;
        // ARMv4 core: BLX forms leave everything alone
        if (!(blx_kind && blx_refused))
        begin
            case (kind)
                btu_pkg::OP_BX, btu_pkg::OP_BX_THUMB:
                begin
                    r.pc = rv; r.thumb = rv[0]; r.pc_we = 1'b1;
                end
                btu_pkg::OP_BLX_REG:
                begin
                    r.lr = pc + btu_pkg::LINK_ARM; r.lr_we = 1'b1;
                    r.pc = rv; r.thumb = rv[0]; r.pc_we = 1'b1;
                end
                btu_pkg::OP_B:
                begin
                    r.pc = pc + arm_off; r.pc_we = 1'b1;
                end
                btu_pkg::OP_BL:
                begin
                    r.lr = pc + btu_pkg::LINK_ARM; r.lr_we = 1'b1;
                    r.pc = pc + arm_off; r.pc_we = 1'b1;
                end
                btu_pkg::OP_BLX_IMM:
                begin
                    r.lr = pc + btu_pkg::LINK_ARM; r.lr_we = 1'b1;
                    r.pc = pc + (arm_off | {30'd0, ins[24], 1'b0});
                    r.thumb = 1'b1; r.pc_we = 1'b1;
                end
                btu_pkg::OP_BLX_REG_T:
                begin
                    r.lr = pc + btu_pkg::LINK_THUMB; r.lr_we = 1'b1;
                    r.pc = rv; r.thumb = rv[0]; r.pc_we = 1'b1;
                end
                btu_pkg::OP_BCOND_THUMB:
                begin
                    if (cond_holds(btu_pkg::cond_t'(ins[11:8]), fl))
                    begin
                        r.pc = pc + t8_off; r.pc_we = 1'b1;
                    end
                end
                btu_pkg::OP_B_THUMB:
                begin
                    r.pc = pc + t11_off; r.pc_we = 1'b1;
                end
                btu_pkg::OP_BL_PREFIX:
                begin
                    r.lr = pc + {t11_off[20:0], 11'd0}; r.lr_we = 1'b1;
                end
                btu_pkg::OP_BL_SUFFIX:
                begin
                    r.pc = lr + suffix_off; r.pc_we = 1'b1;
                    r.lr = pc + btu_pkg::LINK_THUMB; r.lr_we = 1'b1;
                end
                btu_pkg::OP_BLX_SUFFIX:
                begin
                    r.pc = lr + suffix_off; r.pc_we = 1'b1;
                    r.lr = pc + btu_pkg::LINK_THUMB; r.lr_we = 1'b1;
                    r.thumb = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        r.flush  = r.pc_we;
        r.cycles = r.pc_we ? btu_pkg::CYCLES_TAKEN : btu_pkg::CYCLES_NONE;
        return r;
    endfunction

    // Track config, queue predictions, compare results in order
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blx_off <= 1'b0;
            expected_results.delete();
            bad_results = 0;
            mismatch_count <= 0;
            in_flight <= 0;
        end
        else
        begin
            if (cfg_we)
                blx_off <= cfg_wdata;
            if (req.valid && req.ready)
                expected_results.push_back(resolve_branch(req.op, req.instruction,
                    req.pc_value, req.lr_value, req.reg_value, req.flags, req.thumb_in,
                    blx_off));
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.pc_out, rsp.pc_write, rsp.lr_out, rsp.lr_write,
                        rsp.thumb_out, rsp.flush, rsp.cycles};
                if (expected_results.size() == 0)
                begin
                    if (bad_results < 10)
                        $display("%0t: result with nothing expected: pc=%h lr=%h",
                                 $time, got.pc, got.lr);
                    bad_results++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        if (bad_results < 10)
                        begin
                            $display("%0t: mismatch", $time);
                            $display("  expected pc=%h pw=%b lr=%h lw=%b t=%b fl=%b cyc=%0d",
                                     want.pc, want.pc_we, want.lr, want.lr_we,
                                     want.thumb, want.flush, want.cycles);
                            $display("  actual   pc=%h pw=%b lr=%h lw=%b t=%b fl=%b cyc=%0d",
                                     got.pc, got.pc_we, got.lr, got.lr_we,
                                     got.thumb, got.flush, got.cycles);
                        end
                        bad_results++;
                    end
                end
            end
            mismatch_count <= bad_results;
            in_flight <= expected_results.size();
        end
    end

endmodule

>>> verif/tb_branch_target_unit.sv
// Testbench top for the branch target unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_branch_target_unit;

    localparam int         PHASES        = 8;
    localparam int         PHASE_ITEMS   = 154;
    localparam int         CYCLE_LIMIT   = 300000;
    localparam logic [3:0] OP_UNUSED_LO  = 4'd12;
    localparam logic [3:0] OP_UNUSED_HI  = 4'd15;
    localparam logic [3:0] THUMB_BCOND   = 4'hD;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] ins;
        logic [31:0] pc;
        logic [31:0] lr;
        logic [31:0] rv;
        logic [3:0]  fl;
        logic        th;
    } branch_req_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   mismatch_count;
    int   in_flight;
    int   send_idle_pct;
    int   stall_pct;
    int   cycle_count;

    btu_req_if req_ch();
    btu_rsp_if rsp_ch();

    branch_target_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    btu_branch_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .mismatch_count (mismatch_count),
        .in_flight      (in_flight)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Stall the result side at random
    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic branch_req_t mk_branch(input logic [3:0] op, input logic [31:0] ins,
                                              input logic [31:0] pc, input logic [31:0] lr,
                                              input logic [31:0] rv, input logic [3:0] fl,
                                              input logic th);
        return '{op, ins, pc, lr, rv, fl, th};
    endfunction

    // Pick an address, now and then one at the edge of the range
    function automatic logic [31:0] pick_addr();
        if ($urandom_range(9) != 0)
            return $urandom;
        case ($urandom_range(3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            default: return 32'h7FFF_FFFE;
        endcase
    endfunction

    function automatic branch_req_t random_branch();
        logic [3:0] op;
        op = ($urandom_range(49) == 0) ? 4'($urandom_range(15, 12)) : 4'($urandom_range(11));
        return mk_branch(op, $urandom, pick_addr(), pick_addr(), pick_addr(),
                         4'($urandom_range(15)), 1'($urandom_range(1)));
    endfunction

    // Present one item, with a random gap ahead of it, and hold until accepted
    task automatic issue_branch(input branch_req_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.op          <= b.op;
        req_ch.instruction <= b.ins;
        req_ch.pc_value    <= b.pc;
        req_ch.lr_value    <= b.lr;
        req_ch.reg_value   <= b.rv;
        req_ch.flags       <= b.fl;
        req_ch.thumb_in    <= b.th;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Drain outstanding items, then write the register
    task automatic write_blx_disabled(input logic v);
        // Let the count take in the last accepted item
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        branch_req_t prefix;
        branch_req_t suffix;
        int          sent;
        int          mode;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.op          = btu_pkg::OP_BX;
        req_ch.instruction = '0;
        req_ch.pc_value    = '0;
        req_ch.lr_value    = '0;
        req_ch.reg_value   = '0;
        req_ch.flags       = '0;
        req_ch.thumb_in    = 1'b0;
        rsp_ch.ready       = 1'b1;
        send_idle_pct      = 0;
        stall_pct          = 0;
        cycle_count        = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_blx_disabled(1'b0);

        // Directed: field extremes, every kind, link wrap, never-taken conditions
        issue_branch(mk_branch(btu_pkg::OP_BX, 32'h0, 32'h100, 32'h0, 32'h0000_0001,
                               4'h0, 1'b0));
        issue_branch(mk_branch(btu_pkg::OP_BX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFE, 4'hF, 1'b1));
        issue_branch(mk_branch(btu_pkg::OP_BLX_REG, 32'h0, 32'h0, 32'h1234, 32'h8000_0003,
                               4'h0, 1'b0));
        issue_branch(mk_branch(btu_pkg::OP_B, 32'h0080_0000, 32'h0, 32'h0, 32'h0,
                               4'h0, 1'b0));
        issue_branch(mk_branch(btu_pkg::OP_B, 32'h007F_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0,
                               4'h0, 1'b0));
        issue_branch(mk_branch(btu_pkg::OP_BL, 32'hFFFF_FFFF, 32'h2, 32'h0, 32'h0,
                               4'h0, 1'b1));
        issue_branch(mk_branch(btu_pkg::OP_BLX_IMM, 32'hFB80_0000, 32'h1000, 32'h0, 32'h0,
                               4'h0, 1'b0));
        issue_branch(mk_branch(btu_pkg::OP_BLX_IMM, 32'h0000_0000, 32'h3, 32'h0, 32'h0,
                               4'h0, 1'b0));
        issue_branch(mk_branch(btu_pkg::OP_BX_THUMB, 32'h0000_4778, 32'h40, 32'h0, 32'h2000,
                               4'h0, 1'b1));
        issue_branch(mk_branch(btu_pkg::OP_BLX_REG_T, 32'h0000_47F8, 32'h0, 32'h0,
                               32'hFFFF_FFFF, 4'h0, 1'b1));
        issue_branch(mk_branch(btu_pkg::OP_BCOND_THUMB,
                               {16'd0, THUMB_BCOND, btu_pkg::COND_EQ, 8'h80},
                               32'h100, 32'h0, 32'h0, 4'h4, 1'b1));
        issue_branch(mk_branch(btu_pkg::OP_BCOND_THUMB,
                               {16'd0, THUMB_BCOND, btu_pkg::COND_GT, 8'h7F},
                               32'h100, 32'h0, 32'h0, 4'h9, 1'b1));
        issue_branch(mk_branch(btu_pkg::OP_BCOND_THUMB,
                               {16'd0, THUMB_BCOND, btu_pkg::COND_AL, 8'h10},
                               32'h100, 32'h0, 32'h0, 4'hF, 1'b1));
        issue_branch(mk_branch(btu_pkg::OP_BCOND_THUMB,
                               {16'd0, THUMB_BCOND, btu_pkg::COND_NV, 8'hFF},
                               32'h100, 32'h0, 32'h0, 4'h0, 1'b1));
        issue_branch(mk_branch(btu_pkg::OP_B_THUMB, 32'h0000_E400, 32'h0, 32'h0, 32'h0,
                               4'h0, 1'b1));
        issue_branch(mk_branch(btu_pkg::OP_B_THUMB, 32'h0000_E3FF, 32'hFFFF_FFFE, 32'h0,
                               32'h0, 4'h0, 1'b1));
        issue_branch(mk_branch(btu_pkg::OP_BL_PREFIX, 32'h0000_F7FF, 32'h0, 32'h0, 32'h0,
                               4'h0, 1'b1));
        issue_branch(mk_branch(btu_pkg::OP_BL_PREFIX, 32'h0000_F400, 32'h8000_0000, 32'h0,
                               32'h0, 4'h0, 1'b1));
        issue_branch(mk_branch(btu_pkg::OP_BL_SUFFIX, 32'h0000_FFFF, 32'h0, 32'hFFFF_FFFF,
                               32'h0, 4'h0, 1'b1));
        issue_branch(mk_branch(btu_pkg::OP_BLX_SUFFIX, 32'h0000_E800, 32'h10, 32'h2000,
                               32'h0, 4'h0, 1'b1));
        issue_branch(mk_branch(OP_UNUSED_LO, 32'hFFFF_FFFF, 32'h55, 32'hAA, 32'h1, 4'hF, 1'b1));
        issue_branch(mk_branch(OP_UNUSED_HI, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0, 1'b0));
        req_ch.valid <= 1'b0;

        // Random phases over the flow-control modes and both register settings
        for (int p = 0; p < PHASES; p++)
        begin
            mode = p % 4;
            write_blx_disabled(1'((p + p / 4) % 2));
            send_idle_pct = (mode == 1) ? 59 : (mode == 3) ? 16 : 0;
            stall_pct     = (mode == 2) ? 59 : (mode == 3) ? 16 : 0;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(3) == 0)
                begin
                    // Well-formed Thumb BL pair: suffix links off the prefix target
                    prefix = random_branch();
                    prefix.op = btu_pkg::OP_BL_PREFIX;
                    prefix.ins[15:11] = 5'b11110;
                    suffix = random_branch();
                    suffix.op = $urandom_range(1) ? btu_pkg::OP_BL_SUFFIX
                                                  : btu_pkg::OP_BLX_SUFFIX;
                    suffix.ins[15:11] = (suffix.op == btu_pkg::OP_BL_SUFFIX) ? 5'b11111
                                                                             : 5'b11101;
                    suffix.pc = prefix.pc + 32'd2;
                    suffix.lr = prefix.pc + {{9{prefix.ins[10]}}, prefix.ins[10:0], 12'd0};
                    suffix.th = 1'b1;
                    issue_branch(prefix);
                    issue_branch(suffix);
                    sent += 2;
                end
                else
                begin
                    issue_branch(random_branch());
                    sent++;
                end
            end
            req_ch.valid <= 1'b0;
        end

        // Let the pipeline empty out
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
